/* rtl/spe_pkg.sv */
// spe_pkg: shared constants for the shortest path engine.
// No dependencies.
`timescale 1ns / 1ps
package spe_pkg;
  localparam int unsigned NumVerticesDefault = 16;
  localparam int unsigned MaxEdgesDefault    = 64;
  localparam int unsigned WeightBitsDefault  = 16;
  localparam int unsigned DistBits           = 20;
  localparam logic [DistBits-1:0] DistMax    = {DistBits{1'b1}};

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StFull    = 2'd1;
  localparam logic [1:0] StBad     = 2'd2;
  localparam logic [1:0] StUnreach = 2'd3;

  localparam logic OpAdd   = 1'b0;
  localparam logic OpQuery = 1'b1;
endpackage

/* rtl/shortest_path_engine_core.sv */
// shortest_path_engine_core: top level of the shortest path engine.
// Depends on spe_pkg.
`timescale 1ns / 1ps
// Usage:
//  s_axis_* carries one request beat: op, vertex_a, vertex_b, edge_weight.
//  m_axis_* returns result beats; tlast marks the final beat of a request.
//  cfg_* writes vertex_count (1..NUM_VERTICES effective); write only when idle.
// Timing:
//  An add goes through S_PICK to its result beat in S_RESP. A query runs a
//  single-source shortest path search with one shared adder/comparator: per
//  settled vertex, a scan over vertex_count entries (one a cycle) then a scan
//  over all stored edges (one a cycle, edge memory read registered). The path
//  is then rebuilt back from the destination (one vertex a cycle) and streamed,
//  source first, one beat a cycle while m_axis_tready is high.
//  The block takes one request at a time; s_axis_tready is low meanwhile.
// Reset: edge count clears, vertex_count goes to 16; the edge memory keeps
//  its contents (only entries below the count are read). No clearing pass.
// Stall: a waiting result beat holds until m_axis_tready; the sequencer
//  waits with it.
module shortest_path_engine_core #(
  parameter int unsigned NUM_VERTICES = spe_pkg::NumVerticesDefault,
  parameter int unsigned MAX_EDGES    = spe_pkg::MaxEdgesDefault,
  parameter int unsigned WEIGHT_BITS  = spe_pkg::WeightBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] op, [4:1] vertex_a, [8:5] vertex_b, [24:9] edge_weight, zero pad
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [5:2] path_vertex, [25:6] total_distance, zero pad
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);
  localparam int unsigned VB = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int unsigned EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CB = $clog2(MAX_EDGES + 1);
  localparam int unsigned DB = spe_pkg::DistBits;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RESP  = 10'b0000000010,
    S_INIT  = 10'b0000000100,
    S_VSCAN = 10'b0000001000,
    S_ESCAN = 10'b0000010000,
    S_RELAX = 10'b0000100000,
    S_BACK  = 10'b0001000000,
    S_OUT   = 10'b0010000000,
    S_ELAST = 10'b0100000000,
    S_PICK  = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic [3:0]            a;
    logic [3:0]            b;
    logic [WEIGHT_BITS-1:0] w;
  } edge_t;

  state_e state_q, state_d;
  logic [4:0] vcount_q;
  logic [CB-1:0] ecount_q;
  edge_t edge_mem [MAX_EDGES];
  edge_t edge_rd_q;
  logic [EB-1:0] rd_addr;

  logic [DB-1:0] dist_q [NUM_VERTICES];
  logic [VB-1:0] pred_q [NUM_VERTICES];
  logic [NUM_VERTICES-1:0] fin_q, reach_q;
  logic [VB-1:0] path_q [NUM_VERTICES];

  logic op_q;
  logic [3:0] src_q, dst_q;
  logic [1:0] rst_st_q;
  logic [VB:0] idx_q, best_q, plen_q, pout_q;
  logic best_ok_q;
  logic [CB-1:0] eidx_q;
  logic [VB-1:0] cur_q, u_q;
  logic [DB-1:0] du_q;

  logic [4:0] vc;
  assign vc = (vcount_q == 5'd0) ? 5'd1 :
              (32'(vcount_q) > NUM_VERTICES) ? 5'(NUM_VERTICES) : vcount_q;

  logic s_fire;
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // shared adder / comparator
  logic [VB-1:0] nb;
  logic nb_hit;
  logic [DB:0] sum;
  logic [DB-1:0] nd;
  always_comb begin
    nb_hit = 1'b0;
    nb = '0;
    if (32'(edge_rd_q.a) == 32'(u_q)) begin
      nb_hit = 1'b1; nb = VB'(edge_rd_q.b);
    end else if (32'(edge_rd_q.b) == 32'(u_q)) begin
      nb_hit = 1'b1; nb = VB'(edge_rd_q.a);
    end
    sum = {1'b0, du_q} + (DB+1)'(edge_rd_q.w);
    nd = sum[DB] ? spe_pkg::DistMax : sum[DB-1:0];
  end

  assign rd_addr = eidx_q[EB-1:0];
  always_ff @(posedge clk_i) begin
    if (s_fire && s_axis_tdata[0] == spe_pkg::OpAdd && ecount_q < CB'(MAX_EDGES)
        && {1'b0, s_axis_tdata[4:1]} < vc && {1'b0, s_axis_tdata[8:5]} < vc)
      edge_mem[ecount_q[EB-1:0]] <= '{a: s_axis_tdata[4:1], b: s_axis_tdata[8:5],
                                     w: WEIGHT_BITS'(s_axis_tdata[24:9])};
    edge_rd_q <= edge_mem[rd_addr];
  end

  logic [VB-1:0] ivx;
  assign ivx = idx_q[VB-1:0];
  logic bad;
  assign bad = ({1'b0, src_q} >= vc) || ({1'b0, dst_q} >= vc);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (s_fire) state_d = S_PICK;
      S_PICK:  if (bad || op_q == spe_pkg::OpAdd) state_d = S_RESP;
               else state_d = S_INIT;
      S_RESP:  if (m_axis_tready) state_d = S_IDLE;
      S_INIT:  state_d = S_VSCAN;
      S_VSCAN: if (idx_q == (VB+1)'(vc)) begin
                 if (!best_ok_q) state_d = reach_q[VB'(dst_q)] ? S_BACK : S_RESP;
                 else if (ecount_q == '0) state_d = S_VSCAN;
                 else state_d = S_ESCAN;
               end
      S_ESCAN: state_d = S_RELAX;
      S_RELAX: if (eidx_q == '0) state_d = S_ELAST; else state_d = S_RELAX;
      S_ELAST: state_d = S_VSCAN;
      S_BACK:  if (32'(cur_q) == 32'(src_q) || 32'(plen_q) + 1 >= 32'(vc))
                 state_d = S_OUT;
      S_OUT:   if (m_axis_tready && pout_q == '0) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      vcount_q <= 5'd16;
      ecount_q <= '0;
      fin_q    <= '0;
      reach_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) vcount_q <= cfg_data_i;
      case (state_q)
        S_IDLE: if (s_fire) begin
          op_q <= s_axis_tdata[0]; src_q <= s_axis_tdata[4:1];
          dst_q <= s_axis_tdata[8:5];
        end
        S_PICK: begin
          if (bad) rst_st_q <= spe_pkg::StBad;
          else if (op_q == spe_pkg::OpAdd) begin
            if (ecount_q < CB'(MAX_EDGES)) begin
              rst_st_q <= spe_pkg::StOk; ecount_q <= ecount_q + 1'b1;
            end else rst_st_q <= spe_pkg::StFull;
          end
        end
        S_INIT: begin
          fin_q <= '0;
          // only the source starts out reached
          reach_q <= {{(NUM_VERTICES-1){1'b0}}, 1'b1} << src_q;
          dist_q[VB'(src_q)] <= '0;
          idx_q <= '0; best_ok_q <= 1'b0;
        end
        S_VSCAN: begin
          if (idx_q == (VB+1)'(vc)) begin
            rst_st_q <= spe_pkg::StUnreach;
            idx_q <= '0; best_ok_q <= 1'b0;
            if (best_ok_q) begin
              u_q <= best_q[VB-1:0];
              du_q <= dist_q[best_q[VB-1:0]];
              fin_q[best_q[VB-1:0]] <= 1'b1;
              eidx_q <= ecount_q - 1'b1;
            end else begin
              cur_q <= VB'(dst_q); plen_q <= '0;
            end
          end else begin
            if (reach_q[ivx] && !fin_q[ivx] &&
                (!best_ok_q || dist_q[ivx] < dist_q[best_q[VB-1:0]])) begin
              best_q <= idx_q; best_ok_q <= 1'b1;
            end
            idx_q <= idx_q + 1'b1;
          end
        end
        S_ESCAN: ;
        S_RELAX, S_ELAST: begin
          if (state_q == S_RELAX) eidx_q <= eidx_q - 1'b1;
          if (nb_hit && {1'b0, 4'(nb)} < vc && !fin_q[nb] &&
              (!reach_q[nb] || nd < dist_q[nb])) begin
            reach_q[nb] <= 1'b1; dist_q[nb] <= nd; pred_q[nb] <= u_q;
          end
        end
        S_BACK: begin
          path_q[plen_q[VB-1:0]] <= cur_q;
          if (32'(cur_q) == 32'(src_q) || 32'(plen_q) + 1 >= 32'(vc)) begin
            pout_q <= plen_q;
          end else begin
            plen_q <= plen_q + 1'b1; cur_q <= pred_q[cur_q];
          end
        end
        S_OUT: if (m_axis_tready) pout_q <= pout_q - 1'b1;
        default: ;
      endcase
    end
  end

  logic [DB-1:0] dd;
  assign dd = dist_q[VB'(dst_q)];
  assign m_axis_tvalid = (state_q == S_RESP) || (state_q == S_OUT);
  assign m_axis_tlast  = 1'b1 & ((state_q == S_RESP) || pout_q == '0);
  assign m_axis_tdata  = (state_q == S_OUT) ?
      {6'd0, dd, 4'(path_q[pout_q[VB-1:0]]), spe_pkg::StOk} :
      {30'd0, rst_st_q};
endmodule
